// ----- sv/pdmp_pkg.sv -----
package pdmp_pkg;

   localparam int KW_COUNT = 7;
   localparam int KW_CHARS_MAX = 8;
   localparam int TYPE_POS_MAX = 15;

   localparam logic [7:0] SEP_CHAR = 8'h7C;
   localparam logic [7:0] DIGIT_LO = 8'h30;
   localparam logic [7:0] DIGIT_HI = 8'h39;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

   localparam logic [3:0] KW_LEN [KW_COUNT] = '{
      4'd8, 4'd6, 4'd5, 4'd3, 4'd5, 4'd8, 4'd5
   };

   localparam logic [7:0] KW_CHARS [KW_COUNT][KW_CHARS_MAX] = '{
      '{"R", "E", "G", "I", "S", "T", "E", "R"},
      '{"S", "T", "A", "T", "U", "S", 8'h00, 8'h00},
      '{"E", "V", "E", "N", "T", 8'h00, 8'h00, 8'h00},
      '{"A", "C", "K", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"Q", "U", "E", "R", "Y", 8'h00, 8'h00, 8'h00},
      '{"R", "E", "S", "P", "O", "N", "S", "E"},
      '{"E", "R", "R", "O", "R", 8'h00, 8'h00, 8'h00}
   };

   typedef enum logic [1:0] {
      KIND_NODE    = 2'd0,
      KIND_DATA    = 2'd1,
      KIND_SUMMARY = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      ERR_NONE     = 4'd0,
      ERR_LENGTH   = 4'd1,
      ERR_NO_SEP1  = 4'd2,
      ERR_TYPE     = 4'd3,
      ERR_NO_SEP2  = 4'd4,
      ERR_ID       = 4'd5,
      ERR_ID_LONG  = 4'd6,
      ERR_NODE     = 4'd7,
      ERR_DATA     = 4'd8
   } error_type;

   // one queue entry: an optional byte result followed by an optional summary
   typedef struct packed {
      logic        has_byte;
      logic        byte_is_data;
      logic [7:0]  char_val;
      logic        has_sum;
      logic [2:0]  type_code;
      logic [31:0] id_value;
      logic [5:0]  node_bytes;
      logic [7:0]  data_bytes;
      error_type   error_code;
   } entry_type;

   function automatic error_type note_error(error_type cur, error_type code);
      note_error = (cur == ERR_NONE) ? code : cur;
   endfunction

endpackage

// ----- sv/pdmp_front.sv -----
module pdmp_front #(
   parameter int MSG_MAX = 512,
   parameter int ID_TEXT_MAX = 16,
   parameter int NODE_MAX = 64,
   parameter int DATA_MAX = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          char_in,
   input  logic                end_of_message,
   output logic                push,
   output pdmp_pkg::entry_type entry
);

   localparam int MSG_W = $clog2(MSG_MAX + 1);
   localparam int DIG_W = $clog2(ID_TEXT_MAX + 1);
   localparam int NODE_W = $clog2(NODE_MAX + 1);
   localparam int DATA_W = $clog2(DATA_MAX + 1);

   typedef enum logic [1:0] {
      PH_TYPE = 2'd0,
      PH_ID   = 2'd1,
      PH_NODE = 2'd2,
      PH_DATA = 2'd3
   } phase_type;

   phase_type            phase_ff, phase_in;
   logic [MSG_W-1:0]     msg_count_ff, msg_count_in;
   logic [6:0]           kw_mask_ff, kw_mask_in;
   logic [3:0]           type_pos_ff, type_pos_in;
   logic [31:0]          id_acc_ff, id_acc_in;
   logic                 id_ovf_ff, id_ovf_in;
   logic [DIG_W-1:0]     id_digits_ff, id_digits_in;
   logic [NODE_W-1:0]    node_count_ff, node_count_in;
   logic [DATA_W-1:0]    data_count_ff, data_count_in;
   pdmp_pkg::error_type  first_err_ff, first_err_in, sum_err;
   logic [35:0]          id_prod;
   logic                 is_sep;
   logic                 byte_out;
   logic                 byte_data;
   logic [2:0]           type_code;

   assign is_sep = (char_in == pdmp_pkg::SEP_CHAR);
   assign id_prod = 36'(id_acc_ff) * 36'd10 + 36'(char_in[3:0]);

   always_comb begin
      phase_in = phase_ff;
      msg_count_in = msg_count_ff;
      kw_mask_in = kw_mask_ff;
      type_pos_in = type_pos_ff;
      id_acc_in = id_acc_ff;
      id_ovf_in = id_ovf_ff;
      id_digits_in = id_digits_ff;
      node_count_in = node_count_ff;
      data_count_in = data_count_ff;
      first_err_in = first_err_ff;
      byte_out = 1'b0;
      byte_data = 1'b0;

      if (32'(msg_count_ff) < MSG_MAX) begin
         msg_count_in = msg_count_ff + 1'b1;
      end

      unique case (phase_ff)
         PH_TYPE: begin
            if (is_sep) begin
               for (int k = 0; k < pdmp_pkg::KW_COUNT; k++) begin
                  if (pdmp_pkg::KW_LEN[k] != type_pos_ff) begin
                     kw_mask_in[k] = 1'b0;
                  end
               end
               if (kw_mask_in == 7'd0) begin
                  first_err_in = pdmp_pkg::note_error(first_err_in, pdmp_pkg::ERR_TYPE);
               end
               phase_in = PH_ID;
            end else begin
               for (int k = 0; k < pdmp_pkg::KW_COUNT; k++) begin
                  if (!(type_pos_ff < pdmp_pkg::KW_LEN[k]
                        && pdmp_pkg::KW_CHARS[k][type_pos_ff[2:0]] == char_in)) begin
                     kw_mask_in[k] = 1'b0;
                  end
               end
               if (32'(type_pos_ff) < pdmp_pkg::TYPE_POS_MAX) begin
                  type_pos_in = type_pos_ff + 1'b1;
               end
            end
         end
         PH_ID: begin
            if (is_sep) begin
               if (id_digits_ff == '0 || id_ovf_ff) begin
                  first_err_in = pdmp_pkg::note_error(first_err_in, pdmp_pkg::ERR_ID);
               end else if (32'(id_digits_ff) >= ID_TEXT_MAX) begin
                  first_err_in = pdmp_pkg::note_error(first_err_in, pdmp_pkg::ERR_ID_LONG);
               end
               phase_in = PH_NODE;
            end else begin
               if (char_in >= pdmp_pkg::DIGIT_LO && char_in <= pdmp_pkg::DIGIT_HI) begin
                  if (!id_ovf_ff) begin
                     if (id_prod[35:32] != 4'd0) begin
                        id_ovf_in = 1'b1;
                     end else begin
                        id_acc_in = id_prod[31:0];
                     end
                  end
               end else begin
                  id_ovf_in = 1'b1;
               end
               if (32'(id_digits_ff) < ID_TEXT_MAX) begin
                  id_digits_in = id_digits_ff + 1'b1;
               end
            end
         end
         PH_NODE: begin
            if (is_sep) begin
               if (node_count_ff == '0 || 32'(node_count_ff) >= NODE_MAX) begin
                  first_err_in = pdmp_pkg::note_error(first_err_in, pdmp_pkg::ERR_NODE);
               end
               phase_in = PH_DATA;
            end else begin
               if (32'(node_count_ff) < NODE_MAX) begin
                  node_count_in = node_count_ff + 1'b1;
               end
               byte_out = 1'b1;
            end
         end
         PH_DATA: begin
            if (32'(data_count_ff) < DATA_MAX) begin
               data_count_in = data_count_ff + 1'b1;
            end
            byte_out = 1'b1;
            byte_data = 1'b1;
         end
         default: begin
            phase_in = PH_TYPE;
         end
      endcase

      // summary error, built on the updated state
      sum_err = first_err_in;
      unique case (phase_in)
         PH_TYPE: sum_err = pdmp_pkg::note_error(sum_err, pdmp_pkg::ERR_NO_SEP1);
         PH_ID:   sum_err = pdmp_pkg::note_error(sum_err, pdmp_pkg::ERR_NO_SEP2);
         PH_NODE: begin
            if (node_count_in == '0 || 32'(node_count_in) >= NODE_MAX) begin
               sum_err = pdmp_pkg::note_error(sum_err, pdmp_pkg::ERR_NODE);
            end
         end
         PH_DATA: begin
            if (32'(data_count_in) >= DATA_MAX) begin
               sum_err = pdmp_pkg::note_error(sum_err, pdmp_pkg::ERR_DATA);
            end
         end
         default: sum_err = first_err_in;
      endcase
      if (32'(msg_count_in) >= MSG_MAX) begin
         sum_err = pdmp_pkg::ERR_LENGTH;
      end

      type_code = 3'd0;
      if (phase_in != PH_TYPE) begin
         for (int k = pdmp_pkg::KW_COUNT - 1; k >= 0; k--) begin
            if (kw_mask_in[k]) begin
               type_code = 3'(k);
            end
         end
      end
   end

   always_comb begin
      push = accept && (byte_out || end_of_message);
      entry.has_byte = byte_out;
      entry.byte_is_data = byte_data;
      entry.char_val = char_in;
      entry.has_sum = end_of_message;
      entry.type_code = type_code;
      entry.id_value = id_acc_in;
      entry.node_bytes = (32'(node_count_in) > 32'd63) ? 6'd63 : 6'(node_count_in);
      entry.data_bytes = (32'(data_count_in) > 32'd255) ? 8'd255 : 8'(data_count_in);
      entry.error_code = sum_err;
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && end_of_message)) begin
         phase_ff <= PH_TYPE;
         msg_count_ff <= '0;
         kw_mask_ff <= '1;
         type_pos_ff <= '0;
         id_acc_ff <= '0;
         id_ovf_ff <= 1'b0;
         id_digits_ff <= '0;
         node_count_ff <= '0;
         data_count_ff <= '0;
         first_err_ff <= pdmp_pkg::ERR_NONE;
      end else if (accept) begin
         phase_ff <= phase_in;
         msg_count_ff <= msg_count_in;
         kw_mask_ff <= kw_mask_in;
         type_pos_ff <= type_pos_in;
         id_acc_ff <= id_acc_in;
         id_ovf_ff <= id_ovf_in;
         id_digits_ff <= id_digits_in;
         node_count_ff <= node_count_in;
         data_count_ff <= data_count_in;
         first_err_ff <= first_err_in;
      end
   end

endmodule

// ----- sv/pdmp_queue.sv -----
module pdmp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  pdmp_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                empty,
   output pdmp_pkg::entry_type head
);

   pdmp_pkg::entry_type               mem_ff [pdmp_pkg::QUEUE_DEPTH];
   logic [pdmp_pkg::QUEUE_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [pdmp_pkg::QUEUE_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [pdmp_pkg::QUEUE_CW-1:0]     count_ff, count_in;
   logic                              do_push, do_pop;

   assign full = (32'(count_ff) == pdmp_pkg::QUEUE_DEPTH);
   assign empty = (count_ff == '0);
   assign head = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == pdmp_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == pdmp_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- sv/pdmp_back.sv -----
module pdmp_back (
   input  logic                clock,
   input  logic                reset,
   input  pdmp_pkg::entry_type head,
   input  logic                head_empty,
   output logic                head_pop,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [1:0]          rsp_kind,
   output logic [7:0]          rsp_char_out,
   output logic [2:0]          rsp_type_code,
   output logic [31:0]         rsp_id_value,
   output logic [5:0]          rsp_node_bytes,
   output logic [7:0]          rsp_data_bytes,
   output logic                rsp_ok,
   output logic [3:0]          rsp_error_code,
   output logic                rsp_last
);

   // set once the byte half of a two-result entry has gone out
   logic half_ff, half_in;
   logic show_byte;
   logic beat;

   assign show_byte = head.has_byte && !half_ff;
   assign beat = rsp_pop && !head_empty;
   assign head_pop = beat && !(show_byte && head.has_sum);
   assign rsp_empty = head_empty;

   always_comb begin
      half_in = half_ff;
      if (beat) begin
         half_in = !head_pop;
      end
   end

   always_comb begin
      if (show_byte) begin
         rsp_kind = head.byte_is_data ? pdmp_pkg::KIND_DATA : pdmp_pkg::KIND_NODE;
         rsp_char_out = head.char_val;
         rsp_type_code = 3'd0;
         rsp_id_value = 32'd0;
         rsp_node_bytes = 6'd0;
         rsp_data_bytes = 8'd0;
         rsp_ok = 1'b0;
         rsp_error_code = pdmp_pkg::ERR_NONE;
         rsp_last = 1'b0;
      end else begin
         rsp_kind = pdmp_pkg::KIND_SUMMARY;
         rsp_char_out = 8'd0;
         rsp_type_code = head.type_code;
         rsp_id_value = head.id_value;
         rsp_node_bytes = head.node_bytes;
         rsp_data_bytes = head.data_bytes;
         rsp_ok = (head.error_code == pdmp_pkg::ERR_NONE);
         rsp_error_code = head.error_code;
         rsp_last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff <= 1'b0;
      end else begin
         half_ff <= half_in;
      end
   end

endmodule

// ----- sv/pipe_delimited_message_parser_core.sv -----
// the parser writes results into the 4-entry result queue; rsp_ shows its head
// throughput: one byte per cycle in while req_full is low; one result per cycle out
// while rsp_empty is low, set by the queue's single read port; a final node or data
// byte gives two results; req_full rises only when the result queue holds 4 entries
// reset (synchronous) clears the parser state and empties the queue, no clearing pass
module pipe_delimited_message_parser_core #(
   parameter int MSG_MAX = 512,
   parameter int ID_TEXT_MAX = 16,
   parameter int NODE_MAX = 64,
   parameter int DATA_MAX = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_char_in,
   input  logic        req_end_of_message,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_char_out,
   output logic [2:0]  rsp_type_code,
   output logic [31:0] rsp_id_value,
   output logic [5:0]  rsp_node_bytes,
   output logic [7:0]  rsp_data_bytes,
   output logic        rsp_ok,
   output logic [3:0]  rsp_error_code,
   output logic        rsp_last
);

   logic                accept;
   logic                push;
   pdmp_pkg::entry_type push_entry;
   pdmp_pkg::entry_type head;
   logic                head_empty;
   logic                head_pop;

   assign accept = req_push && !req_full;

   pdmp_front #(
      .MSG_MAX(MSG_MAX),
      .ID_TEXT_MAX(ID_TEXT_MAX),
      .NODE_MAX(NODE_MAX),
      .DATA_MAX(DATA_MAX)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .char_in(req_char_in),
      .end_of_message(req_end_of_message),
      .push(push),
      .entry(push_entry)
   );

   pdmp_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_entry(push_entry),
      .full(req_full),
      .pop(head_pop),
      .empty(head_empty),
      .head(head)
   );

   pdmp_back u_back (
      .clock(clock),
      .reset(reset),
      .head(head),
      .head_empty(head_empty),
      .head_pop(head_pop),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_kind(rsp_kind),
      .rsp_char_out(rsp_char_out),
      .rsp_type_code(rsp_type_code),
      .rsp_id_value(rsp_id_value),
      .rsp_node_bytes(rsp_node_bytes),
      .rsp_data_bytes(rsp_data_bytes),
      .rsp_ok(rsp_ok),
      .rsp_error_code(rsp_error_code),
      .rsp_last(rsp_last)
   );

endmodule

// ----- bench/parser_scoreboard_pkg.sv -----
package parser_scoreboard_pkg;

   localparam int MSG_LIMIT = 512;
   localparam int ID_TEXT_LIMIT = 16;
   localparam int NODE_LIMIT = 64;
   localparam int DATA_LIMIT = 256;

   typedef enum logic [2:0] {
      TYPE_REGISTER = 3'd0,
      TYPE_STATUS   = 3'd1,
      TYPE_EVENT    = 3'd2,
      TYPE_ACK      = 3'd3,
      TYPE_QUERY    = 3'd4,
      TYPE_RESPONSE = 3'd5,
      TYPE_ERROR    = 3'd6
   } msg_type;

   typedef enum logic [1:0] {
      SEC_TYPE = 2'd0,
      SEC_ID   = 2'd1,
      SEC_NODE = 2'd2,
      SEC_DATA = 2'd3
   } section_type;

   typedef struct packed {
      pdmp_pkg::kind_type  kind;
      logic [7:0]          char_out;
      logic [2:0]          type_code;
      logic [31:0]         id_value;
      logic [5:0]          node_bytes;
      logic [7:0]          data_bytes;
      logic                ok;
      pdmp_pkg::error_type error_code;
      logic                last;
   } parse_result_type;

   function automatic string keyword_text(msg_type t);
      case (t)
         TYPE_REGISTER: keyword_text = "REGISTER";
         TYPE_STATUS:   keyword_text = "STATUS";
         TYPE_EVENT:    keyword_text = "EVENT";
         TYPE_ACK:      keyword_text = "ACK";
         TYPE_QUERY:    keyword_text = "QUERY";
         TYPE_RESPONSE: keyword_text = "RESPONSE";
         default:       keyword_text = "ERROR";
      endcase
   endfunction

   class parser_scoreboard;
      section_type         section;
      logic [9:0]          msg_count;
      logic [6:0]          type_mask;
      logic [3:0]          type_pos;
      logic [31:0]         id_acc;
      logic                id_bad;
      logic [4:0]          id_digits;
      logic [6:0]          node_count;
      logic [8:0]          data_count;
      pdmp_pkg::error_type first_error;
      parse_result_type    pending_results[$];
      int                  failures;

      function new();
         failures = 0;
         clear_message();
      endfunction

      function void clear_message();
         section = SEC_TYPE;
         msg_count = '0;
         type_mask = 7'h7F;
         type_pos = '0;
         id_acc = '0;
         id_bad = 1'b0;
         id_digits = '0;
         node_count = '0;
         data_count = '0;
         first_error = pdmp_pkg::ERR_NONE;
      endfunction

      function void keep_first_error(pdmp_pkg::error_type code);
         if (first_error == pdmp_pkg::ERR_NONE) first_error = code;
      endfunction

      function void check_node_length();
         if (node_count == 0 || node_count >= NODE_LIMIT) keep_first_error(pdmp_pkg::ERR_NODE);
      endfunction

      function void expect_byte(pdmp_pkg::kind_type k, logic [7:0] c);
         parse_result_type r;
         r = '0;
         r.kind = k;
         r.char_out = c;
         pending_results.push_back(r);
      endfunction

      // accepted input beat: update the parse state and queue what it yields
      function void note_byte(logic [7:0] c, logic eom);
         parse_result_type r;
         string            kw;
         logic [35:0]      next_id;
         if (msg_count < MSG_LIMIT) msg_count++;
         case (section)
            SEC_TYPE: begin
               if (c == pdmp_pkg::SEP_CHAR) begin
                  for (int k = 0; k < pdmp_pkg::KW_COUNT; k++) begin
                     kw = keyword_text(msg_type'(k));
                     if (kw.len() != type_pos) type_mask[k] = 1'b0;
                  end
                  if (type_mask == '0) keep_first_error(pdmp_pkg::ERR_TYPE);
                  section = SEC_ID;
               end else begin
                  for (int k = 0; k < pdmp_pkg::KW_COUNT; k++) begin
                     kw = keyword_text(msg_type'(k));
                     if (type_pos >= kw.len() || kw[type_pos] != c) type_mask[k] = 1'b0;
                  end
                  if (type_pos < pdmp_pkg::TYPE_POS_MAX) type_pos++;
               end
            end
            SEC_ID: begin
               if (c == pdmp_pkg::SEP_CHAR) begin
                  if (id_digits == 0 || id_bad) keep_first_error(pdmp_pkg::ERR_ID);
                  else if (id_digits >= ID_TEXT_LIMIT) keep_first_error(pdmp_pkg::ERR_ID_LONG);
                  section = SEC_NODE;
               end else begin
                  if (c >= pdmp_pkg::DIGIT_LO && c <= pdmp_pkg::DIGIT_HI) begin
                     if (!id_bad) begin
                        next_id = id_acc * 36'd10 + 36'(c - pdmp_pkg::DIGIT_LO);
                        if (next_id > 36'hFFFF_FFFF) id_bad = 1'b1;
                        else id_acc = next_id[31:0];
                     end
                  end else begin
                     id_bad = 1'b1;
                  end
                  if (id_digits < ID_TEXT_LIMIT) id_digits++;
               end
            end
            SEC_NODE: begin
               if (c == pdmp_pkg::SEP_CHAR) begin
                  check_node_length();
                  section = SEC_DATA;
               end else begin
                  if (node_count < NODE_LIMIT) node_count++;
                  expect_byte(pdmp_pkg::KIND_NODE, c);
               end
            end
            default: begin
               if (data_count < DATA_LIMIT) data_count++;
               expect_byte(pdmp_pkg::KIND_DATA, c);
            end
         endcase

         if (eom) begin
            case (section)
               SEC_TYPE: keep_first_error(pdmp_pkg::ERR_NO_SEP1);
               SEC_ID:   keep_first_error(pdmp_pkg::ERR_NO_SEP2);
               SEC_NODE: check_node_length();
               default:  if (data_count >= DATA_LIMIT) keep_first_error(pdmp_pkg::ERR_DATA);
            endcase
            if (msg_count >= MSG_LIMIT) first_error = pdmp_pkg::ERR_LENGTH;
            r = '0;
            r.kind = pdmp_pkg::KIND_SUMMARY;
            if (section != SEC_TYPE)
               for (int k = pdmp_pkg::KW_COUNT - 1; k >= 0; k--)
                  if (type_mask[k]) r.type_code = 3'(k);
            r.id_value = id_acc;
            r.node_bytes = (node_count > 63) ? 6'd63 : node_count[5:0];
            r.data_bytes = (data_count > 255) ? 8'd255 : data_count[7:0];
            r.ok = (first_error == pdmp_pkg::ERR_NONE);
            r.error_code = first_error;
            r.last = 1'b1;
            pending_results.push_back(r);
            clear_message();
         end
      endfunction

      function void check_field(string name, logic [31:0] want, logic [31:0] got,
                                longint unsigned now);
         if (want !== got) begin
            failures++;
            $display("%0d ns: %s mismatch, expected %0d, actual %0d", now, name, want, got);
         end
      endfunction

      function void check_result(parse_result_type got, longint unsigned now);
         parse_result_type want;
         if (pending_results.size() == 0) begin
            failures++;
            $display("%0d ns: unexpected result, expected none, actual kind %0d char %0d",
                     now, got.kind, got.char_out);
            return;
         end
         want = pending_results.pop_front();
         check_field("kind", want.kind, got.kind, now);
         check_field("char_out", want.char_out, got.char_out, now);
         check_field("type_code", want.type_code, got.type_code, now);
         check_field("id_value", want.id_value, got.id_value, now);
         check_field("node_bytes", want.node_bytes, got.node_bytes, now);
         check_field("data_bytes", want.data_bytes, got.data_bytes, now);
         check_field("ok", want.ok, got.ok, now);
         check_field("error_code", want.error_code, got.error_code, now);
         check_field("last", want.last, got.last, now);
      endfunction
   endclass

endpackage

// ----- bench/testbench.sv -----
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_BYTES = 150;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [7:0]  req_char_in;
   logic        req_end_of_message;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_char_out;
   logic [2:0]  rsp_type_code;
   logic [31:0] rsp_id_value;
   logic [5:0]  rsp_node_bytes;
   logic [7:0]  rsp_data_bytes;
   logic        rsp_ok;
   logic [3:0]  rsp_error_code;
   logic        rsp_last;

   parser_scoreboard_pkg::parser_scoreboard board;
   parser_scoreboard_pkg::parse_result_type got;
   logic [7:0]       msg_bytes[$];
   int unsigned      bytes_sent = 0;
   int unsigned      send_idle_pct = 0;
   int unsigned      pop_stall_pct = 0;

   pipe_delimited_message_parser_core #(
      .MSG_MAX(parser_scoreboard_pkg::MSG_LIMIT),
      .ID_TEXT_MAX(parser_scoreboard_pkg::ID_TEXT_LIMIT),
      .NODE_MAX(parser_scoreboard_pkg::NODE_LIMIT),
      .DATA_MAX(parser_scoreboard_pkg::DATA_LIMIT)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_char_in(req_char_in),
      .req_end_of_message(req_end_of_message),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_kind(rsp_kind),
      .rsp_char_out(rsp_char_out),
      .rsp_type_code(rsp_type_code),
      .rsp_id_value(rsp_id_value),
      .rsp_node_bytes(rsp_node_bytes),
      .rsp_data_bytes(rsp_data_bytes),
      .rsp_ok(rsp_ok),
      .rsp_error_code(rsp_error_code),
      .rsp_last(rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
   end

   // accepted beats on both sides
   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full) board.note_byte(req_char_in, req_end_of_message);
         if (rsp_pop && !rsp_empty) begin
            got.kind = pdmp_pkg::kind_type'(rsp_kind);
            got.char_out = rsp_char_out;
            got.type_code = rsp_type_code;
            got.id_value = rsp_id_value;
            got.node_bytes = rsp_node_bytes;
            got.data_bytes = rsp_data_bytes;
            got.ok = rsp_ok;
            got.error_code = pdmp_pkg::error_type'(rsp_error_code);
            got.last = rsp_last;
            board.check_result(got, $time);
         end
      end
   end

   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(255, 1)); while (b == pdmp_pkg::SEP_CHAR);
      return b;
   endfunction

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) msg_bytes.push_back(s[i]);
   endtask

   task automatic add_digits(int n);
      repeat (n) msg_bytes.push_back(pdmp_pkg::DIGIT_LO + 8'($urandom_range(9)));
   endtask

   task automatic add_plain(int n);
      repeat (n) msg_bytes.push_back(plain_byte());
   endtask

   task automatic add_any(int n);
      repeat (n)
         msg_bytes.push_back($urandom_range(7) == 0 ? pdmp_pkg::SEP_CHAR
                                                     : 8'($urandom_range(255, 1)));
   endtask

   task automatic send_beat(logic [7:0] c, logic eom);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_char_in <= c;
      req_end_of_message <= eom;
      do @(posedge clock); while (req_full);
      @(negedge clock);
   endtask

   task automatic send_message();
      for (int i = 0; i < msg_bytes.size(); i++)
         send_beat(msg_bytes[i], i == msg_bytes.size() - 1);
      bytes_sent += msg_bytes.size();
      msg_bytes.delete();
   endtask

   task automatic send_text(string s);
      add_text(s);
      send_message();
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      do @(negedge clock); while (board.pending_results.size() != 0);
   endtask

   task automatic build_random_message();
      parser_scoreboard_pkg::msg_type t;
      if ($urandom_range(99) >= 85) begin
         // noise
         repeat ($urandom_range(20, 1))
            msg_bytes.push_back($urandom_range(2) == 0 ? pdmp_pkg::SEP_CHAR
                                                        : 8'($urandom_range(255, 1)));
         return;
      end
      t = parser_scoreboard_pkg::msg_type'($urandom_range(parser_scoreboard_pkg::TYPE_ERROR));
      add_text(parser_scoreboard_pkg::keyword_text(t));
      case ($urandom_range(19))
         0: msg_bytes[$urandom_range(msg_bytes.size() - 1)] = plain_byte();
         1: void'(msg_bytes.pop_back());
         2: msg_bytes.push_back("S");
         default: ;
      endcase
      msg_bytes.push_back(pdmp_pkg::SEP_CHAR);
      case ($urandom_range(19))
         0: ;
         1: begin
            add_text("0000000000");
            add_digits($urandom_range(10, 6));
         end
         2: begin
            add_digits($urandom_range(3));
            msg_bytes.push_back(plain_byte());
            add_digits($urandom_range(3));
         end
         3: begin
            if ($urandom_range(1)) add_text("4294967295");
            else add_text("4294967296");
         end
         default: add_digits($urandom_range(10, 1));
      endcase
      msg_bytes.push_back(pdmp_pkg::SEP_CHAR);
      case ($urandom_range(19))
         0: ;
         1: add_plain($urandom_range(parser_scoreboard_pkg::NODE_LIMIT + 2,
                                     parser_scoreboard_pkg::NODE_LIMIT - 2));
         default: add_plain($urandom_range(8, 1));
      endcase
      case ($urandom_range(59))
         24: begin
            msg_bytes.push_back(pdmp_pkg::SEP_CHAR);
            add_any($urandom_range(parser_scoreboard_pkg::DATA_LIMIT + 3,
                                   parser_scoreboard_pkg::DATA_LIMIT - 3));
         end
         default: begin
            if ($urandom_range(9) >= 4) begin
               msg_bytes.push_back(pdmp_pkg::SEP_CHAR);
               add_any($urandom_range(12));
            end
         end
      endcase
      // cut short now and then
      if ($urandom_range(9) == 0)
         while (msg_bytes.size() > 1 && $urandom_range(3) != 0) void'(msg_bytes.pop_back());
   endtask

   initial begin
      #2ms;
      $display("** pipe_delimited_message_parser_core: FAILED **");
      $finish;
   end

   initial begin
      int          extra[2];
      int unsigned goal;
      extra = '{0, 1};
      board = new();
      reset = 1'b1;
      req_push = 1'b0;
      req_char_in = 8'h00;
      req_end_of_message = 1'b0;
      send_idle_pct = 12;
      pop_stall_pct = 81;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_text("REGISTER|0|N");
      send_text("STATUS|4294967295|AB|x|y");
      send_text("EVENT|4294967296|n");
      send_text("ACK|12a|n|d");
      send_text("QUERY||n");
      send_text("RESPONSE|0000000000000001|n");
      send_text("ERROR|000000000000001|n|");
      send_text("ERROR|7|");
      send_text("REGIS");
      send_text("ACK|12");
      send_text("ACKX|1|n");
      send_text("|");
      send_text("RESPONSEXXXXXXXXXXX|1|n");
      // byte extremes in node and data
      add_text("ACK|1|");
      msg_bytes.push_back(8'h01);
      msg_bytes.push_back(8'hFF);
      msg_bytes.push_back(pdmp_pkg::SEP_CHAR);
      msg_bytes.push_back(8'hFF);
      msg_bytes.push_back(8'h01);
      send_message();
      for (int i = 0; i < 2; i++) begin
         add_text("EVENT|9|");
         add_plain(parser_scoreboard_pkg::NODE_LIMIT - 1 + extra[i]);
         send_message();
      end
      add_text("STATUS|3|nd|");
      add_any(parser_scoreboard_pkg::DATA_LIMIT);
      send_message();
      // message length at the limit
      add_text("QUERY|5|node|");
      add_any(parser_scoreboard_pkg::MSG_LIMIT - 13);
      send_message();
      wait_drained();

      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               send_idle_pct = 12;
               pop_stall_pct = 81;
            end
            1: begin
               send_idle_pct = 81;
               pop_stall_pct = 12;
            end
            default: begin
               send_idle_pct = 0;
               pop_stall_pct = 0;
            end
         endcase
         goal = bytes_sent + RANDOM_BYTES / 3;
         while (bytes_sent < goal) begin
            build_random_message();
            send_message();
         end
         wait_drained();
      end

      repeat (10) @(negedge clock);
      if (board.failures == 0 && board.pending_results.size() == 0)
         $display("** pipe_delimited_message_parser_core: PASSED **");
      else
         $display("** pipe_delimited_message_parser_core: FAILED **");
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/pdmp_pkg.sv
sv/pdmp_front.sv
sv/pdmp_queue.sv
sv/pdmp_back.sv
sv/pipe_delimited_message_parser_core.sv
bench/parser_scoreboard_pkg.sv
bench/testbench.sv
